[hw/rtl/rni_pkg.sv]
// Shared constants, codes and control types of the recurrent-net inference engine.
package rni_pkg;

	localparam int DATA_BITS         = 16;
	localparam int FRAC              = 11;
	localparam int ACC_BITS          = 40;
	localparam int MEMORY_SIZE_DEF   = 63;
	localparam int HIDDEN_SIZE_DEF   = 64;
	localparam int HIDDEN_LAYERS_DEF = 1;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_SAMPLE = 2'd2;

	localparam logic [1:0] SRC_REC = 2'd0;
	localparam logic [1:0] SRC_X   = 2'd1;
	localparam logic [1:0] SRC_HID = 2'd2;

	localparam logic [1:0] DST_HID  = 2'd0;
	localparam logic [1:0] DST_REC  = 2'd1;
	localparam logic [1:0] DST_PRED = 2'd2;

	typedef logic signed [DATA_BITS-1:0] data_t;

	typedef struct packed {
		logic       issue;
		logic       bias;
		logic       last;
		logic [1:0] src;
		logic [1:0] dest;
		logic       act;
		logic       load_param;
		logic       load_start;
		logic       load_sample;
		logic       copy_rd;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic row_done;
		logic out_free;
	} dp_sts_t;

endpackage

[hw/rtl/recurrent_net_inference.sv]
// Top level of the recurrent-net inference engine: sequencer plus datapath.
// Input channel (in_valid/in_stall) carries one item per transfer: kind 0 writes
// one parameter word at param_index (weights and biases layer by layer, then the
// initial memory), kind 1 starts a sequence, kind 2 runs one sample step, kind 3
// is dropped. Write items never stall the input; a start item stalls it while
// the initial memory is copied into the recurrent memory.
// A sample step streams every weight through one multiply-accumulate unit, one
// word per cycle while a row's columns are walked, pausing after each row
// until its result (through the softsign divider on hidden rows) is written
// back; the single weight-store read port sets this pace.
// Only sample items give a result on the output channel (out_valid/out_stall):
// prediction, step_index and the saturated flag. The result is held in an
// output register while the receiver stalls; further write and start items are
// still taken, and a finished step waits until the register is free.
// Reset clears the recurrent memory, last prediction, step counter and teacher
// limit; the weight store and initial memory hold garbage until written.
module recurrent_net_inference
	import rni_pkg::*;
#(
	parameter int MEMORY_SIZE   = MEMORY_SIZE_DEF,
	parameter int HIDDEN_SIZE   = HIDDEN_SIZE_DEF,
	parameter int HIDDEN_LAYERS = HIDDEN_LAYERS_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [13:0] param_index,
	input  data_t       param_value,
	input  logic [15:0] teacher_steps,
	input  data_t       sample,
	output logic        out_valid,
	input  logic        out_stall,
	output data_t       prediction,
	output logic [15:0] step_index,
	output logic        saturated
);

	localparam int VEC   = MEMORY_SIZE + 1;
	localparam int NMAX  = (VEC > HIDDEN_SIZE) ? VEC : HIDDEN_SIZE;
	localparam int CW    = $clog2(NMAX);
	localparam int STORE = VEC * HIDDEN_SIZE + HIDDEN_SIZE
		+ HIDDEN_LAYERS * (HIDDEN_SIZE * HIDDEN_SIZE + HIDDEN_SIZE)
		+ HIDDEN_SIZE * VEC + VEC;
	localparam int WA_W  = $clog2(STORE);
	localparam int HA_W  = $clog2((HIDDEN_LAYERS + 1) * HIDDEN_SIZE);

	dp_cmd_t         cmd;
	dp_sts_t         sts;
	logic [WA_W-1:0] w_addr;
	logic [CW-1:0]   col;
	logic [CW-1:0]   row;
	logic [HA_W-1:0] hid_rd_addr;
	logic [HA_W-1:0] hid_wr_addr;

	rni_ctrl #(
		.MEMORY_SIZE   (MEMORY_SIZE),
		.HIDDEN_SIZE   (HIDDEN_SIZE),
		.HIDDEN_LAYERS (HIDDEN_LAYERS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.sts         (sts),
		.cmd         (cmd),
		.w_addr      (w_addr),
		.col         (col),
		.row         (row),
		.hid_rd_addr (hid_rd_addr),
		.hid_wr_addr (hid_wr_addr)
	);

	rni_dp #(
		.MEMORY_SIZE   (MEMORY_SIZE),
		.HIDDEN_SIZE   (HIDDEN_SIZE),
		.HIDDEN_LAYERS (HIDDEN_LAYERS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.w_addr        (w_addr),
		.col           (col),
		.row           (row),
		.hid_rd_addr   (hid_rd_addr),
		.hid_wr_addr   (hid_wr_addr),
		.param_index   (param_index),
		.param_value   (param_value),
		.teacher_steps (teacher_steps),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.prediction    (prediction),
		.step_index    (step_index),
		.saturated     (saturated)
	);

endmodule

[hw/rtl/rni_div.sv]
// Softsign unit: rounded |v|*2048/(2048+|v|), negated for negative v, one quotient bit per cycle.
module rni_div
	import rni_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  data_t value,
	output logic  done,
	output data_t quot
);

	localparam int QB  = FRAC + 1;
	localparam int MW  = DATA_BITS + 1;
	localparam int DW  = DATA_BITS + 2;
	localparam int NW  = DATA_BITS + FRAC + 2;
	localparam int CNW = $clog2(QB + 1);

	logic [MW-1:0]  mag;
	logic [DW-1:0]  den;
	logic [NW-1:0]  num;
	logic [NW-1:0]  rem_q;
	logic [NW-1:0]  dsh_q;
	logic [QB-1:0]  q_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           neg_q;
	logic           done_q;
	logic           ge;

	always_comb begin
		mag = value[DATA_BITS-1] ? MW'(-$signed({value[DATA_BITS-1], value})) : MW'(value);
		den = DW'(1 << FRAC) + DW'(mag);
		num = (NW'(mag) << FRAC) + NW'(den >> 1);
		ge  = rem_q >= dsh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NW'(den) << (QB - 1);
			q_q   <= '0;
			neg_q <= value[DATA_BITS-1];
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			q_q   <= {q_q[QB-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -DATA_BITS'(q_q) : DATA_BITS'(q_q);

endmodule

[hw/rtl/rni_ctrl.sv]
// Sequencer: walks layers, rows and columns and issues datapath commands.
module rni_ctrl
	import rni_pkg::*;
#(
	parameter int MEMORY_SIZE   = MEMORY_SIZE_DEF,
	parameter int HIDDEN_SIZE   = HIDDEN_SIZE_DEF,
	parameter int HIDDEN_LAYERS = HIDDEN_LAYERS_DEF,
	localparam int VEC   = MEMORY_SIZE + 1,
	localparam int NMAX  = (VEC > HIDDEN_SIZE) ? VEC : HIDDEN_SIZE,
	localparam int CW    = $clog2(NMAX),
	localparam int W0    = VEC * HIDDEN_SIZE,
	localparam int WH    = HIDDEN_SIZE * HIDDEN_SIZE,
	localparam int WO    = HIDDEN_SIZE * VEC,
	localparam int STORE = W0 + HIDDEN_SIZE + HIDDEN_LAYERS * (WH + HIDDEN_SIZE) + WO + VEC,
	localparam int WA_W  = $clog2(STORE),
	localparam int HA_W  = $clog2((HIDDEN_LAYERS + 1) * HIDDEN_SIZE)
)(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      kind,
	input  dp_sts_t         sts,
	output dp_cmd_t         cmd,
	output logic [WA_W-1:0] w_addr,
	output logic [CW-1:0]   col,
	output logic [CW-1:0]   row,
	output logic [HA_W-1:0] hid_rd_addr,
	output logic [HA_W-1:0] hid_wr_addr
);

	localparam int LW = $clog2(HIDDEN_LAYERS + 2);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_COPY = 3'd1;
	localparam logic [2:0] S_BIAS = 3'd2;
	localparam logic [2:0] S_COLS = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	logic [2:0]      state_q;
	logic [LW-1:0]   layer_q;
	logic [CW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [WA_W-1:0] bias_addr_q;
	logic [WA_W-1:0] rowbase_q;
	logic [WA_W-1:0] wa_q;
	logic [HA_W-1:0] rb_q;
	logic [HA_W-1:0] wb_q;

	logic            accept;
	logic            last_layer;
	logic [CW-1:0]   nin_m1;
	logic [CW-1:0]   nout_m1;
	logic [WA_W-1:0] nout_step;
	logic [WA_W-1:0] next_wblk;
	logic [WA_W-1:0] next_base;

	always_comb begin
		accept     = in_valid && (state_q == S_IDLE);
		last_layer = layer_q == LW'(HIDDEN_LAYERS + 1);
		nin_m1     = (layer_q == '0) ? CW'(VEC - 1) : CW'(HIDDEN_SIZE - 1);
		nout_m1    = last_layer ? CW'(VEC - 1) : CW'(HIDDEN_SIZE - 1);
		nout_step  = last_layer ? WA_W'(VEC) : WA_W'(HIDDEN_SIZE);
		next_wblk  = (layer_q == LW'(HIDDEN_LAYERS)) ? WA_W'(WO) : WA_W'(WH);
		next_base  = bias_addr_q + 1'b1;
	end

	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (kind)
				KIND_WRITE:  cmd.load_param  = 1'b1;
				KIND_START:  cmd.load_start  = 1'b1;
				KIND_SAMPLE: cmd.load_sample = 1'b1;
				default: ;
			endcase
		end
		cmd.copy_rd = state_q == S_COPY;
		cmd.issue   = (state_q == S_BIAS) || (state_q == S_COLS);
		cmd.bias    = state_q == S_BIAS;
		cmd.last    = (state_q == S_COLS) && (col_q == nin_m1);
		if (layer_q == '0) begin
			cmd.src = (col_q < CW'(MEMORY_SIZE)) ? SRC_REC : SRC_X;
		end else begin
			cmd.src = SRC_HID;
		end
		if (!last_layer) begin
			cmd.dest = DST_HID;
		end else begin
			cmd.dest = (row_q < CW'(MEMORY_SIZE)) ? DST_REC : DST_PRED;
		end
		cmd.act  = !last_layer;
		cmd.emit = (state_q == S_EMIT) && sts.out_free;
	end

	assign in_stall    = state_q != S_IDLE;
	assign w_addr      = (state_q == S_BIAS) ? bias_addr_q : wa_q;
	assign col         = col_q;
	assign row         = row_q;
	assign hid_rd_addr = rb_q + HA_W'(col_q);
	assign hid_wr_addr = wb_q + HA_W'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			layer_q     <= '0;
			row_q       <= '0;
			col_q       <= '0;
			bias_addr_q <= '0;
			rowbase_q   <= '0;
			wa_q        <= '0;
			rb_q        <= '0;
			wb_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_start) begin
						col_q   <= '0;
						state_q <= S_COPY;
					end else if (cmd.load_sample) begin
						layer_q     <= '0;
						row_q       <= '0;
						bias_addr_q <= WA_W'(W0);
						rowbase_q   <= '0;
						wa_q        <= '0;
						rb_q        <= '0;
						wb_q        <= '0;
						state_q     <= S_BIAS;
					end
				end
				S_COPY: begin
					col_q <= col_q + 1'b1;
					if (col_q == CW'(MEMORY_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_BIAS: begin
					col_q   <= '0;
					state_q <= S_COLS;
				end
				S_COLS: begin
					wa_q  <= wa_q + nout_step;
					col_q <= col_q + 1'b1;
					if (cmd.last) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (sts.row_done) begin
						if (row_q == nout_m1) begin
							if (last_layer) begin
								state_q <= S_EMIT;
							end else begin
								layer_q     <= layer_q + 1'b1;
								row_q       <= '0;
								rowbase_q   <= next_base;
								wa_q        <= next_base;
								bias_addr_q <= next_base + next_wblk;
								rb_q        <= wb_q;
								wb_q        <= wb_q + HA_W'(HIDDEN_SIZE);
								state_q     <= S_BIAS;
							end
						end else begin
							row_q       <= row_q + 1'b1;
							bias_addr_q <= bias_addr_q + 1'b1;
							rowbase_q   <= rowbase_q + 1'b1;
							wa_q        <= rowbase_q + 1'b1;
							state_q     <= S_BIAS;
						end
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/rni_dp.sv]
// Datapath: parameter stores, vector buffers, multiply-accumulate, writeback and output register.
module rni_dp
	import rni_pkg::*;
#(
	parameter int MEMORY_SIZE   = MEMORY_SIZE_DEF,
	parameter int HIDDEN_SIZE   = HIDDEN_SIZE_DEF,
	parameter int HIDDEN_LAYERS = HIDDEN_LAYERS_DEF,
	localparam int VEC   = MEMORY_SIZE + 1,
	localparam int NMAX  = (VEC > HIDDEN_SIZE) ? VEC : HIDDEN_SIZE,
	localparam int CW    = $clog2(NMAX),
	localparam int STORE = VEC * HIDDEN_SIZE + HIDDEN_SIZE
		+ HIDDEN_LAYERS * (HIDDEN_SIZE * HIDDEN_SIZE + HIDDEN_SIZE)
		+ HIDDEN_SIZE * VEC + VEC,
	localparam int WA_W  = $clog2(STORE),
	localparam int HDEP  = (HIDDEN_LAYERS + 1) * HIDDEN_SIZE,
	localparam int HA_W  = $clog2(HDEP)
)(
	input  logic            clk,
	input  logic            arst_n,
	input  dp_cmd_t         cmd,
	output dp_sts_t         sts,
	input  logic [WA_W-1:0] w_addr,
	input  logic [CW-1:0]   col,
	input  logic [CW-1:0]   row,
	input  logic [HA_W-1:0] hid_rd_addr,
	input  logic [HA_W-1:0] hid_wr_addr,
	input  logic [13:0]     param_index,
	input  data_t           param_value,
	input  logic [15:0]     teacher_steps,
	input  data_t           sample,
	output logic            out_valid,
	input  logic            out_stall,
	output data_t           prediction,
	output logic [15:0]     step_index,
	output logic            saturated
);

	localparam int MA_W = (MEMORY_SIZE > 1) ? $clog2(MEMORY_SIZE) : 1;
	localparam int PW   = 2 * DATA_BITS;
	localparam int DMAX = 2 ** (DATA_BITS - 1) - 1;

	data_t wmem [STORE];
	data_t imem [MEMORY_SIZE];
	data_t rmem [MEMORY_SIZE];
	data_t hmem [HDEP];
	logic [MEMORY_SIZE-1:0] rvld_q;

	logic [31:0]     pidx;
	logic [31:0]     ioff;
	logic            w_hit;
	logic            i_hit;
	logic [MA_W-1:0] rec_rd;
	logic [MA_W-1:0] rec_wr;

	data_t           init_s1;
	logic            copy_s1;
	logic [MA_W-1:0] copy_addr_s1;

	data_t      w_s1;
	data_t      rec_s1;
	data_t      hid_s1;
	logic       rvld_s1;
	logic       v_s1;
	logic       bias_s1;
	logic       last_s1;
	logic [1:0] src_s1;

	logic signed [PW-1:0] prod_s2;
	logic                 v_s2;
	logic                 bias_s2;
	logic                 last_s2;

	logic signed [ACC_BITS-1:0] acc_q;
	logic                       fin_q;

	data_t                    vin;
	logic signed [PW-1:0]     prod_c;
	logic signed [ACC_BITS:0] sum_c;
	logic signed [ACC_BITS:0] rnd_c;
	logic signed [ACC_BITS:0] sh_c;
	data_t                    wb_c;
	logic                     wb_sat;

	logic  div_done;
	data_t div_q;
	logic  wr_en;
	data_t wr_val;

	data_t       x_q;
	data_t       last_pred_q;
	logic [15:0] step_q;
	logic [15:0] limit_q;
	logic        sat_q;
	logic        out_valid_q;
	data_t       pred_q;
	logic [15:0] step_out_q;
	logic        sat_out_q;

	always_comb begin
		pidx   = 32'(param_index);
		ioff   = pidx - 32'(STORE);
		w_hit  = pidx < 32'(STORE);
		i_hit  = !w_hit && (ioff < 32'(MEMORY_SIZE));
		rec_rd = col[MA_W-1:0];
		rec_wr = row[MA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_param && w_hit) begin
			wmem[pidx[WA_W-1:0]] <= param_value;
		end
		if (cmd.issue) begin
			w_s1 <= wmem[w_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_param && i_hit) begin
			imem[ioff[MA_W-1:0]] <= param_value;
		end
		if (cmd.copy_rd) begin
			init_s1 <= imem[rec_rd];
		end
		copy_addr_s1 <= rec_rd;
	end

	always_ff @(posedge clk) begin
		if (copy_s1) begin
			rmem[copy_addr_s1] <= init_s1;
		end else if (wr_en && (cmd.dest == DST_REC)) begin
			rmem[rec_wr] <= wr_val;
		end
		if (cmd.issue) begin
			rec_s1 <= rmem[rec_rd];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (cmd.dest == DST_HID)) begin
			hmem[hid_wr_addr] <= wr_val;
		end
		if (cmd.issue) begin
			hid_s1 <= hmem[hid_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q  <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (copy_s1) begin
				rvld_q[copy_addr_s1] <= 1'b1;
			end else if (wr_en && (cmd.dest == DST_REC)) begin
				rvld_q[rec_wr] <= 1'b1;
			end
			if (cmd.issue) begin
				rvld_s1 <= rvld_q[rec_rd];
			end
		end
	end

	always_comb begin
		unique case (src_s1)
			SRC_REC: vin = rvld_s1 ? rec_s1 : '0;
			SRC_X:   vin = x_q;
			default: vin = hid_s1;
		endcase
		prod_c = bias_s1 ? (PW'(w_s1) <<< FRAC) : PW'(vin) * PW'(w_s1);
		sum_c  = (ACC_BITS + 1)'(acc_q) + (ACC_BITS + 1)'(prod_s2);
		rnd_c  = (ACC_BITS + 1)'(acc_q) + (ACC_BITS + 1)'(1 << (FRAC - 1));
		sh_c   = rnd_c >>> FRAC;
		wb_sat = 1'b0;
		if (sh_c > (ACC_BITS + 1)'(DMAX)) begin
			wb_c   = data_t'(DMAX);
			wb_sat = 1'b1;
		end else if (sh_c < -(ACC_BITS + 1)'(DMAX + 1)) begin
			wb_c   = data_t'(-DMAX - 1);
			wb_sat = 1'b1;
		end else begin
			wb_c = sh_c[DATA_BITS-1:0];
		end
		wr_en  = (fin_q && !cmd.act) || div_done;
		wr_val = div_done ? div_q : wb_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_s1 <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			copy_s1 <= cmd.copy_rd;
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			fin_q   <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		bias_s1 <= cmd.bias;
		last_s1 <= cmd.last;
		src_s1  <= cmd.src;
		bias_s2 <= bias_s1;
		last_s2 <= last_s1;
		prod_s2 <= prod_c;
		if (v_s2) begin
			if (bias_s2) begin
				acc_q <= ACC_BITS'(prod_s2);
			end else if (sum_c[ACC_BITS] != sum_c[ACC_BITS-1]) begin
				acc_q <= sum_c[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
					: {1'b0, {(ACC_BITS-1){1'b1}}};
			end else begin
				acc_q <= sum_c[ACC_BITS-1:0];
			end
		end
	end

	rni_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fin_q && cmd.act),
		.value  (wb_c),
		.done   (div_done),
		.quot   (div_q)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			x_q <= (step_q < limit_q) ? sample : last_pred_q;
		end
		if (cmd.emit) begin
			pred_q     <= last_pred_q;
			step_out_q <= step_q;
			sat_out_q  <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pred_q <= '0;
			step_q      <= '0;
			limit_q     <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_start) begin
				limit_q     <= teacher_steps;
				step_q      <= '0;
				last_pred_q <= '0;
			end
			if (cmd.load_sample) begin
				sat_q <= 1'b0;
			end else if (fin_q && wb_sat) begin
				sat_q <= 1'b1;
			end
			if (wr_en && (cmd.dest == DST_PRED)) begin
				last_pred_q <= wr_val;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (step_q != '1) begin
					step_q <= step_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.row_done = wr_en;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign prediction   = pred_q;
	assign step_index   = step_out_q;
	assign saturated    = sat_out_q;

endmodule
